[rtl/bhd_pkg.sv]
// bhd_pkg: shared types and constants for the BFS hop-distance block.
// No dependencies; imported by bfs_hop_distance_top.
`default_nettype none

package bhd_pkg;

    localparam int MAX_NODES_DEF = 64;   // default node capacity
    localparam int NODE_W        = 6;    // node index / hop field width
    localparam int NCNT_W        = 7;    // node count / reached count width

    localparam logic [NCNT_W-1:0] NODE_COUNT_RST = 7'd64;

    typedef enum logic [1:0] {
        CMD_ADD_EDGE = 2'd0,
        CMD_SEARCH   = 2'd1,
        CMD_READ     = 2'd2,
        CMD_CLEAR    = 2'd3
    } t_cmd;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    typedef struct packed {
        t_cmd              cmd;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
    } t_req;

    typedef struct packed {
        logic              status;
        logic [NODE_W-1:0] distance;
        logic              reachable;
        logic [NCNT_W-1:0] reached_count;
    } t_rsp;

endpackage

`default_nettype wire

[rtl/bhd_ram.sv]
// bhd_ram: generic single-clock RAM, one write port, one registered read port.
// Depends on nothing; holds no reset state.
`default_nettype none

module bhd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/bfs_hop_distance_top.sv]
// bfs_hop_distance_top: graph store and breadth-first search engine, top level.
// Uses bhd_pkg (types, codes) and bhd_ram (adjacency, hop and queue memories).
//
// Usage:
//  - Request channel (i_req_valid / o_req_stall, payload i_req): one command
//    per request: add edge, run search, read distance, clear graph.
//  - Response channel (o_rsp_valid / i_rsp_stall, payload o_rsp): exactly
//    one response per request, in request order.
//  - Config: i_cfg_we / i_cfg_wdata writes node_count; write only while idle.
//  - One request is processed at a time. A search handles each node taken
//    off the frontier queue in steps: queue read, row read, then expansion,
//    which enqueues the newly discovered nodes one by one. These steps are
//    set by the single registered read port of the adjacency memory.
//  - The response register lets the next request be accepted while a
//    response still waits; a finished result is held internally until the
//    response register frees up, and o_req_stall stays high meanwhile.
//  - Reset (synchronous, active low) empties the graph via per-row valid
//    bits, clears visited bits and sets node_count to 64. No clearing pass.
`default_nettype none

module bfs_hop_distance_top #(
    parameter int MAX_NODES = bhd_pkg::MAX_NODES_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_req_valid,
    output logic                           o_req_stall,
    input  wire bhd_pkg::t_req             i_req,
    output logic                           o_rsp_valid,
    input  wire logic                      i_rsp_stall,
    output bhd_pkg::t_rsp                  o_rsp,
    input  wire logic                      i_cfg_we,
    input  wire logic [bhd_pkg::NCNT_W-1:0] i_cfg_wdata
);

    import bhd_pkg::*;

    localparam int AW = $clog2(MAX_NODES);     // node address into memories
    localparam int CW = $clog2(MAX_NODES + 1); // queue pointers, 0..MAX_NODES

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_ADD_WA,
        S_ADD_RB,
        S_ADD_WB,
        S_POP,
        S_FETCH,
        S_LOAD,
        S_EXPAND,
        S_READ_WAIT,
        S_DONE
    } t_state;

    t_state                 r_state, n_state;
    t_req                   r_req, n_req;
    t_rsp                   r_res, n_res;      // result being built
    t_rsp                   r_rsp, n_rsp;      // response register
    logic                   r_rsp_valid, n_rsp_valid;
    logic [NCNT_W-1:0]      r_node_count;
    logic [MAX_NODES-1:0]   r_adj_vld, n_adj_vld;  // row written since clear
    logic [MAX_NODES-1:0]   r_visited, n_visited;
    logic [MAX_NODES-1:0]   r_fresh, n_fresh;      // neighbors left to enqueue
    logic [CW-1:0]          r_head, n_head;
    logic [CW-1:0]          r_tail, n_tail;
    logic [AW-1:0]          r_u, n_u;              // node being expanded
    logic [NODE_W-1:0]      r_hop_nxt, n_hop_nxt;  // hop(u) + 1

    // memory ports
    logic                   adj_we, adj_re;
    logic [AW-1:0]          adj_waddr, adj_raddr;
    logic [MAX_NODES-1:0]   adj_wdata, adj_rdata;
    logic                   hop_we, hop_re;
    logic [AW-1:0]          hop_waddr, hop_raddr;
    logic [NODE_W-1:0]      hop_wdata, hop_rdata;
    logic                   q_we, q_re;
    logic [AW-1:0]          q_waddr, q_raddr;
    logic [AW-1:0]          q_wdata, q_rdata;

    // derived values
    logic [NCNT_W-1:0]      eff_count;
    logic [MAX_NODES-1:0]   in_use;
    logic [AW-1:0]          idx_a, idx_b;
    logic [MAX_NODES-1:0]   oh_a, oh_b;
    logic                   bad_index;
    logic [MAX_NODES-1:0]   row_cur, fresh_new;
    logic [MAX_NODES-1:0]   pick_oh;
    logic [AW-1:0]          pick_idx;

    bhd_ram #(.WIDTH(MAX_NODES), .DEPTH(MAX_NODES)) u_adj_ram (
        .i_clk  (i_clk),
        .i_we   (adj_we),
        .i_waddr(adj_waddr),
        .i_wdata(adj_wdata),
        .i_re   (adj_re),
        .i_raddr(adj_raddr),
        .o_rdata(adj_rdata)
    );

    bhd_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_hop_ram (
        .i_clk  (i_clk),
        .i_we   (hop_we),
        .i_waddr(hop_waddr),
        .i_wdata(hop_wdata),
        .i_re   (hop_re),
        .i_raddr(hop_raddr),
        .o_rdata(hop_rdata)
    );

    bhd_ram #(.WIDTH(AW), .DEPTH(MAX_NODES)) u_queue_ram (
        .i_clk  (i_clk),
        .i_we   (q_we),
        .i_waddr(q_waddr),
        .i_wdata(q_wdata),
        .i_re   (q_re),
        .i_raddr(q_raddr),
        .o_rdata(q_rdata)
    );

    // Effective node count: register clamped to capacity.
    assign eff_count = (r_node_count > NCNT_W'(MAX_NODES)) ? NCNT_W'(MAX_NODES)
                                                           : r_node_count;

    always_comb begin
        for (int i = 0; i < MAX_NODES; i++) begin
            in_use[i] = (NCNT_W'(i) < eff_count);
        end
    end

    assign idx_a = r_req.node_a[AW-1:0];
    assign idx_b = r_req.node_b[AW-1:0];
    assign oh_a  = {{(MAX_NODES-1){1'b0}}, 1'b1} << idx_a;
    assign oh_b  = {{(MAX_NODES-1){1'b0}}, 1'b1} << idx_b;

    // clear ignores both indices; node_b only matters for add edge
    assign bad_index = ((r_req.cmd != CMD_CLEAR) && ({1'b0, r_req.node_a} >= eff_count))
                    || ((r_req.cmd == CMD_ADD_EDGE) && ({1'b0, r_req.node_b} >= eff_count));

    // A row never written since the last clear reads as empty.
    always_comb begin
        unique case (r_state)
            S_ADD_WA: row_cur = r_adj_vld[idx_a] ? adj_rdata : '0;
            S_ADD_WB: row_cur = r_adj_vld[idx_b] ? adj_rdata : '0;
            default:  row_cur = r_adj_vld[r_u]   ? adj_rdata : '0;
        endcase
    end

    assign fresh_new = row_cur & in_use & ~r_visited;

    // lowest pending neighbor
    assign pick_oh = r_fresh & (~r_fresh + {{(MAX_NODES-1){1'b0}}, 1'b1});

    always_comb begin
        pick_idx = '0;
        for (int i = 0; i < MAX_NODES; i++) begin
            if (pick_oh[i]) begin
                pick_idx = pick_idx | AW'(i);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_res       = r_res;
        n_rsp       = r_rsp;
        n_rsp_valid = r_rsp_valid;
        n_adj_vld   = r_adj_vld;
        n_visited   = r_visited;
        n_fresh     = r_fresh;
        n_head      = r_head;
        n_tail      = r_tail;
        n_u         = r_u;
        n_hop_nxt   = r_hop_nxt;

        adj_we = 1'b0; adj_waddr = '0; adj_wdata = '0; adj_re = 1'b0; adj_raddr = '0;
        hop_we = 1'b0; hop_waddr = '0; hop_wdata = '0; hop_re = 1'b0; hop_raddr = '0;
        q_we   = 1'b0; q_waddr   = '0; q_wdata   = '0; q_re   = 1'b0; q_raddr   = '0;

        if (r_rsp_valid && !i_rsp_stall) begin
            n_rsp_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_req   = i_req;
                    n_state = S_DISPATCH;
                end
            end

            S_DISPATCH: begin
                n_res = '0;
                if (bad_index) begin
                    n_res.status = STATUS_RANGE;
                    n_state      = S_DONE;
                end else begin
                    unique case (r_req.cmd)
                        CMD_ADD_EDGE: begin
                            adj_re    = 1'b1;
                            adj_raddr = idx_a;
                            n_state   = S_ADD_WA;
                        end
                        CMD_SEARCH: begin
                            // seed: source visited at hop 0, queue = {source}
                            n_visited = oh_a;
                            hop_we    = 1'b1;
                            hop_waddr = idx_a;
                            hop_wdata = '0;
                            q_we      = 1'b1;
                            q_waddr   = '0;
                            q_wdata   = idx_a;
                            n_head    = '0;
                            n_tail    = CW'(1);
                            n_state   = S_POP;
                        end
                        CMD_READ: begin
                            if (r_visited[idx_a]) begin
                                hop_re    = 1'b1;
                                hop_raddr = idx_a;
                                n_state   = S_READ_WAIT;
                            end else begin
                                n_state   = S_DONE;
                            end
                        end
                        CMD_CLEAR: begin
                            n_adj_vld = '0;
                            n_state   = S_DONE;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end

            S_ADD_WA: begin
                adj_we           = 1'b1;
                adj_waddr        = idx_a;
                adj_wdata        = row_cur | oh_b;
                n_adj_vld[idx_a] = 1'b1;
                n_state          = S_ADD_RB;
            end

            S_ADD_RB: begin
                // separate read so a self loop sees the row just written
                adj_re    = 1'b1;
                adj_raddr = idx_b;
                n_state   = S_ADD_WB;
            end

            S_ADD_WB: begin
                adj_we           = 1'b1;
                adj_waddr        = idx_b;
                adj_wdata        = row_cur | oh_a;
                n_adj_vld[idx_b] = 1'b1;
                n_state          = S_DONE;
            end

            S_POP: begin
                if (r_head < r_tail) begin
                    q_re    = 1'b1;
                    q_raddr = r_head[AW-1:0];
                    n_state = S_FETCH;
                end else begin
                    // every reached node was enqueued exactly once
                    n_res.reached_count = NCNT_W'(r_tail);
                    n_state             = S_DONE;
                end
            end

            S_FETCH: begin
                n_u       = q_rdata;
                adj_re    = 1'b1;
                adj_raddr = q_rdata;
                hop_re    = 1'b1;
                hop_raddr = q_rdata;
                n_head    = r_head + CW'(1);
                n_state   = S_LOAD;
            end

            S_LOAD: begin
                n_fresh   = fresh_new;
                n_visited = r_visited | fresh_new;
                n_hop_nxt = hop_rdata + NODE_W'(1);
                n_state   = S_EXPAND;
            end

            S_EXPAND: begin
                if (r_fresh == '0) begin
                    n_state = S_POP;
                end else begin
                    hop_we    = 1'b1;
                    hop_waddr = pick_idx;
                    hop_wdata = r_hop_nxt;
                    q_we      = 1'b1;
                    q_waddr   = r_tail[AW-1:0];
                    q_wdata   = pick_idx;
                    n_tail    = r_tail + CW'(1);
                    n_fresh   = r_fresh & ~pick_oh;
                end
            end

            S_READ_WAIT: begin
                n_res.distance  = hop_rdata;
                n_res.reachable = 1'b1;
                n_state         = S_DONE;
            end

            S_DONE: begin
                // hand over once the response register is free or draining
                if (!r_rsp_valid || !i_rsp_stall) begin
                    n_rsp       = r_res;
                    n_rsp_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_rsp_valid  <= 1'b0;
            r_node_count <= NODE_COUNT_RST;
            r_adj_vld    <= '0;
            r_visited    <= '0;
            r_head       <= '0;
            r_tail       <= '0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
            r_adj_vld   <= n_adj_vld;
            r_visited   <= n_visited;
            r_head      <= n_head;
            r_tail      <= n_tail;
            if (i_cfg_we) begin
                r_node_count <= i_cfg_wdata;
            end
        end
        r_req     <= n_req;
        r_res     <= n_res;
        r_rsp     <= n_rsp;
        r_fresh   <= n_fresh;
        r_u       <= n_u;
        r_hop_nxt <= n_hop_nxt;
    end

    assign o_req_stall = (r_state != S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // queue pointers stay ordered
    a_head_le_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= r_tail)
        else $error("queue head passed tail");

    // an enqueue never overruns the queue
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXPAND && r_fresh != '0) |-> (r_tail < CW'(MAX_NODES)))
        else $error("frontier queue overrun");

    // a range error carries no other result
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_res.status == STATUS_RANGE)
            |-> (r_res.distance == '0 && r_res.reachable == 1'b0
                 && r_res.reached_count == '0))
        else $error("error result with nonzero fields");

endmodule

`default_nettype wire
